FILE: sv/pls_pkg.sv
// pls_pkg: constants, request and status codes, and the cell control type
// for the positional list store. No dependencies.
package pls_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_MODIFY = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } cell_op_t;

endpackage

FILE: sv/positional_list_store.sv
// positional_list_store: ordered list of signed 32-bit values held in a row
// of shifting cells. Depends on pls_pkg and pls_cell.
//
//   channel   | handshake     | fields
//   ----------+---------------+-------------------------------------------
//   request   | start / busy  | req_type, append, position, item_value
//   result    | done (strobe) | status, read_value, list_length
//
// A request is taken while start is high; done is high for a single cycle
// in the cycle after it, with the result on the result ports. Cells at and
// past the position move together, so a new request is taken every cycle;
// busy stays low. Reset empties the list (length zero); cell contents are
// not cleared. The receiver cannot stall; results are never held back.
module positional_list_store
    import pls_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                req_type,
    input  logic                      append,
    input  logic [POS_W-1:0]          position,
    input  logic signed [DATA_W-1:0]  item_value,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [DATA_W-1:0]  read_value,
    output logic [LEN_W-1:0]          list_length
);

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      done_reg;
    logic [1:0]                status_reg, status_next;
    logic signed [DATA_W-1:0]  read_value_reg, read_value_next;

    logic [CMP_W-1:0]          count_ext;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          eff_pos;
    logic [IDX_W-1:0]          pos_idx;
    logic                      ins_ok, mod_ok, rem_ok, rd_ok;

    logic signed [DATA_W-1:0]  cell_data [CAPACITY];
    cell_op_t                  cell_op   [CAPACITY];

    assign busy      = 1'b0;
    assign count_ext = CMP_W'(count_reg);
    assign pos_ext   = CMP_W'(position);
    assign eff_pos   = (append) ? count_ext : pos_ext;
    assign pos_idx   = pos_ext[IDX_W-1:0];

    always_comb
    begin
        status_next     = ST_DONE;
        read_value_next = '0;
        count_next      = count_reg;
        ins_ok          = 1'b0;
        mod_ok          = 1'b0;
        rem_ok          = 1'b0;
        rd_ok           = 1'b0;
        case (req_type)
            REQ_INSERT:
            begin
                if (count_ext == CMP_W'(CAPACITY))
                    status_next = ST_FULL;
                else if (eff_pos > count_ext)
                    status_next = ST_RANGE;
                else
                begin
                    ins_ok     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_MODIFY:
            begin
                if (pos_ext >= count_ext)
                    status_next = ST_RANGE;
                else
                    mod_ok = 1'b1;
            end
            REQ_REMOVE:
            begin
                if (pos_ext >= count_ext)
                    status_next = ST_RANGE;
                else
                begin
                    rem_ok     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_READ:
            begin
                if (pos_ext >= count_ext)
                    status_next = ST_RANGE;
                else
                begin
                    rd_ok           = 1'b1;
                    read_value_next = cell_data[pos_idx];
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_d;
            logic signed [DATA_W-1:0] right_d;

            if (i == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[i+1];
            end

            always_comb
            begin
                cell_op[i] = CELL_HOLD;
                if (start && ins_ok)
                begin
                    if (CMP_W'(i) == eff_pos)
                        cell_op[i] = CELL_LOAD;
                    else if (CMP_W'(i) > eff_pos)
                        cell_op[i] = CELL_LEFT;
                end
                else if (start && mod_ok)
                begin
                    if (CMP_W'(i) == pos_ext)
                        cell_op[i] = CELL_LOAD;
                end
                else if (start && rem_ok)
                begin
                    if (CMP_W'(i) >= pos_ext)
                        cell_op[i] = CELL_RIGHT;
                end
            end

            pls_cell u_cell (
                .clk        (clk),
                .op         (cell_op[i]),
                .load_data  (item_value),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (start)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg     <= status_next;
            read_value_reg <= (rd_ok) ? read_value_next : '0;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign list_length = count_ext[LEN_W-1:0];

endmodule

FILE: sv/pls_cell.sv
// pls_cell: one list slot; holds, loads a new value, or takes the entry of
// its left or right neighbor. Depends on pls_pkg.
module pls_cell
    import pls_pkg::*;
(
    input  logic                      clk,
    input  cell_op_t                  op,
    input  logic signed [DATA_W-1:0]  load_data,
    input  logic signed [DATA_W-1:0]  left_data,
    input  logic signed [DATA_W-1:0]  right_data,
    output logic signed [DATA_W-1:0]  data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        case (op)
            CELL_HOLD:  data_next = data_reg;
            CELL_LOAD:  data_next = load_data;
            CELL_LEFT:  data_next = left_data;
            CELL_RIGHT: data_next = right_data;
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
